>>> rtl/core/icalc_pkg.sv
// ----------------------------------------------------------------------------
// Integer calculator package
// Shared operation codes, widths and control types for the calculator ALU.
// ----------------------------------------------------------------------------
package icalc_pkg;

  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned ModeWidth        = 3;

  localparam logic [ModeWidth-1:0] OpAdd  = 3'd0;
  localparam logic [ModeWidth-1:0] OpSub  = 3'd1;
  localparam logic [ModeWidth-1:0] OpMul  = 3'd2;
  localparam logic [ModeWidth-1:0] OpDiv  = 3'd3;
  localparam logic [ModeWidth-1:0] OpPow  = 3'd4;
  localparam logic [ModeWidth-1:0] OpRem  = 3'd5;
  localparam logic [ModeWidth-1:0] OpFact = 3'd6;
  localparam logic [ModeWidth-1:0] OpMax  = 3'd7;

  // Command from the sequencer to the serial multiply/divide unit.
  typedef struct packed {
    logic start;
    logic divide;
  } md_cmd_t;

endpackage

>>> rtl/core/icalc_muldiv.sv
// ----------------------------------------------------------------------------
// Serial multiply/divide unit
// Shift-add multiplier (low half only) and restoring divider on unsigned
// magnitudes, one bit per cycle.
// ----------------------------------------------------------------------------
module icalc_muldiv #(
  parameter int unsigned DataWidth = icalc_pkg::DataWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  icalc_pkg::md_cmd_t   cmd_i,
  input  logic [DataWidth-1:0] op_x_i,
  input  logic [DataWidth-1:0] op_y_i,
  output logic                 done_o,
  output logic [DataWidth-1:0] prod_o,
  output logic [DataWidth-1:0] quot_o,
  output logic [DataWidth-1:0] rem_o
);

  localparam int unsigned CntWidth = $clog2(DataWidth + 1);

  logic                 busy_q, busy_d;
  logic                 div_q, div_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [DataWidth-1:0] acc_q, acc_d;   // product or partial remainder
  logic [DataWidth-1:0] x_q, x_d;       // multiplicand shift or dividend/quotient
  logic [DataWidth-1:0] y_q, y_d;       // multiplier shift or divisor
  logic                 done_q, done_d;
  logic [DataWidth:0]   trial;

  assign trial = {acc_q, x_q[DataWidth-1]} - {1'b0, y_q};

  // One multiplier bit or one quotient bit per cycle.
  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      div_d  = cmd_i.divide;
      cnt_d  = CntWidth'(DataWidth);
      acc_d  = '0;
      x_d    = op_x_i;
      y_d    = op_y_i;
    end else if (busy_q) begin
      if (div_q) begin
        if (!trial[DataWidth]) begin
          acc_d = trial[DataWidth-1:0];
          x_d   = {x_q[DataWidth-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[DataWidth-2:0], x_q[DataWidth-1]};
          x_d   = {x_q[DataWidth-2:0], 1'b0};
        end
      end else begin
        if (y_q[0]) begin
          acc_d = acc_q + x_q;
        end
        x_d = {x_q[DataWidth-2:0], 1'b0};
        y_d = {1'b0, y_q[DataWidth-1:1]};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      div_q  <= div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
  assign quot_o = x_q;
  assign rem_o  = acc_q;

  // The count never runs while the unit is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0)
    else $error("muldiv counter state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without work");

endmodule

>>> rtl/core/integer_calculator_alu_unit.sv
// Add, sub, max and out-of-range cases go from accept through StWait to StOut.
// Multiply and divide/remainder pass through StMul or StDiv (one bit per cycle).
// Power takes up to 2 * (DataWidth - 1) multiplies and factorial up to
// 2 * DataWidth - 2 multiplies. One item at a time: the next beat is accepted
// only once the sequencer is back in StIdle after the result beat leaves.
// Reset (rst_ni low, asynchronous) clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
// Integer calculator ALU
// Sequencer that drives a shared bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
module integer_calculator_alu_unit #(
  parameter int unsigned DataWidth = icalc_pkg::DataWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [DataWidth-1:0] operand_a_i,
  input  logic [DataWidth-1:0] operand_b_i,
  input  logic [2:0]           mode_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DataWidth-1:0] result_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StPow  = 3'd3;
  localparam logic [2:0] StFact = 3'd4;
  localparam logic [2:0] StWait = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;
  localparam int unsigned EW = $clog2(2 * DataWidth + 1);

  logic [2:0]           state_q, state_d;
  logic [DataWidth-1:0] a_q, a_d, b_q, b_d, acc_q, acc_d, base_q, base_d, res_q, res_d;
  logic [2:0]           mode_q, mode_d;
  logic                 sq_q, sq_d;       // power: next multiply squares the base
  logic                 go_q, go_d;       // a multiply is in flight
  logic [EW-1:0]        fi_q, fi_d;       // factorial index
  logic                 ov_q, ov_d;
  icalc_pkg::md_cmd_t   cmd;
  logic [DataWidth-1:0] mx, my, prod, quot, rem;
  logic                 md_done;
  logic                 neg_a, neg_b;
  logic [DataWidth-1:0] mag_a, mag_b;

  assign neg_a = a_q[DataWidth-1];
  assign neg_b = b_q[DataWidth-1];
  assign mag_a = neg_a ? (~a_q + 1'b1) : a_q;
  assign mag_b = neg_b ? (~b_q + 1'b1) : b_q;

  icalc_muldiv #(.DataWidth(DataWidth)) u_md (
    .clk_i, .rst_ni, .cmd_i(cmd), .op_x_i(mx), .op_y_i(my),
    .done_o(md_done), .prod_o(prod), .quot_o(quot), .rem_o(rem)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q; a_d = a_q; b_d = b_q; mode_d = mode_q;
    acc_d = acc_q; base_d = base_q; res_d = res_q; sq_d = sq_q;
    go_d = go_q; fi_d = fi_q; ov_d = ov_q;
    cmd = '0; mx = a_q; my = b_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          a_d = operand_a_i; b_d = operand_b_i; mode_d = mode_i;
          state_d = StWait;
        end
      end
      StWait: begin
        unique case (mode_q) inside
          icalc_pkg::OpAdd: begin res_d = a_q + b_q; state_d = StOut; end
          icalc_pkg::OpSub: begin res_d = a_q - b_q; state_d = StOut; end
          icalc_pkg::OpMax: begin
            res_d = ($signed(a_q) < $signed(b_q)) ? b_q : a_q; state_d = StOut;
          end
          icalc_pkg::OpMul: begin cmd.start = 1'b1; state_d = StMul; end
          icalc_pkg::OpDiv, icalc_pkg::OpRem: begin
            if (b_q == '0) begin
              res_d = '1; state_d = StOut;
            end else begin
              cmd.start = 1'b1; cmd.divide = 1'b1; mx = mag_a; my = mag_b;
              state_d = StDiv;
            end
          end
          icalc_pkg::OpPow: begin
            acc_d = DataWidth'(1); base_d = a_q; sq_d = 1'b0; go_d = 1'b0;
            if (b_q == '0 || neg_b) begin
              res_d = DataWidth'(1); state_d = StOut;
            end else begin
              state_d = StPow;
            end
          end
          default: begin
            acc_d = DataWidth'(1); fi_d = EW'(2); go_d = 1'b0;
            if (neg_a || a_q >= DataWidth'(2 * DataWidth)) begin
              res_d = '0; state_d = StOut;
            end else begin
              state_d = StFact;
            end
          end
        endcase
      end
      StMul: begin
        if (md_done) begin res_d = prod; state_d = StOut; end
      end
      StDiv: begin
        if (md_done) begin
          if (mode_q == icalc_pkg::OpRem) begin
            res_d = neg_a ? (~rem + 1'b1) : rem;
          end else begin
            res_d = (neg_a != neg_b) ? (~quot + 1'b1) : quot;
          end
          state_d = StOut;
        end
      end
      StPow: begin
        // Alternate: multiply acc by base when the exponent bit is set, then square.
        if (!go_q) begin
          if (b_q == '0) begin
            res_d = acc_q; state_d = StOut;
          end else if (!sq_q && b_q[0]) begin
            cmd.start = 1'b1; mx = acc_q; my = base_q; go_d = 1'b1;
          end else begin
            cmd.start = 1'b1; mx = base_q; my = base_q; go_d = 1'b1; sq_d = 1'b1;
          end
        end else if (md_done) begin
          go_d = 1'b0;
          if (sq_q) begin
            base_d = prod; sq_d = 1'b0; b_d = {1'b0, b_q[DataWidth-1:1]};
          end else begin
            acc_d = prod; sq_d = 1'b1;
          end
        end
      end
      StFact: begin
        if (!go_q) begin
          if (DataWidth'(fi_q) > a_q) begin
            res_d = acc_q; state_d = StOut;
          end else begin
            cmd.start = 1'b1; mx = acc_q; my = DataWidth'(fi_q); go_d = 1'b1;
          end
        end else if (md_done) begin
          go_d = 1'b0; acc_d = prod; fi_d = fi_q + 1'b1;
        end
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    ov_d = (state_d == StOut);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      go_q    <= 1'b0;
      sq_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      sq_q    <= sq_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; mode_q <= mode_d; acc_q <= acc_d;
    base_q <= base_d; res_q <= res_d; fi_q <= fi_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = ov_q;
  assign result_o    = res_q;

  // Output valid tracks the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q == (state_q == StOut)) else $error("valid mismatch");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o))
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during result");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer calculator ALU testbench
// Drives operand pairs and operation codes into the calculator, predicts each
// result with a local model of the arithmetic, and checks every output beat in
// order. Directed corner cases are followed by random phases with different
// amounts of sender idling and receiver stalling, and by one long stall.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned Width      = 32;
  localparam int unsigned CycleLimit = 10000000;
  localparam int unsigned MaxReports = 10;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [Width-1:0] operand_a_i = '0;
  logic [Width-1:0] operand_b_i = '0;
  logic [2:0]       mode_i = icalc_pkg::OpAdd;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [Width-1:0] result_o;

  // Results still owed by the block, oldest first.
  logic [Width-1:0] pending_results[$];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned error_count    = 0;
  int unsigned sent_count     = 0;
  int unsigned checked_count  = 0;
  int unsigned op_count[8];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles    = 0;

  integer_calculator_alu_unit #(.DataWidth(Width)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .mode_i     (mode_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Truncating signed divide; the remainder follows the dividend's sign.
  function automatic logic [Width-1:0] divide_result(input logic [Width-1:0] a,
                                                     input logic [Width-1:0] b,
                                                     input logic want_rem);
    logic [Width-1:0] mag_a, mag_b, quot, rmd;
    if (b == '0) return '1;
    mag_a = a[Width-1] ? -a : a;
    mag_b = b[Width-1] ? -b : b;
    quot  = mag_a / mag_b;
    rmd   = mag_a % mag_b;
    if (want_rem) return a[Width-1] ? -rmd : rmd;
    return (a[Width-1] != b[Width-1]) ? -quot : quot;
  endfunction

  // Square-and-multiply power, wrapping at the data width.
  function automatic logic [Width-1:0] power_result(input logic [Width-1:0] base_in,
                                                    input logic [Width-1:0] expo_in);
    logic [Width-1:0] acc, base, expo;
    acc  = 1;
    base = base_in;
    expo = expo_in;
    if (expo == '0 || expo[Width-1]) return 1;
    while (expo != '0) begin
      if (expo[0]) acc = acc * base;
      base = base * base;
      expo = expo >> 1;
    end
    return acc;
  endfunction

  function automatic logic [Width-1:0] factorial_result(input logic [Width-1:0] a);
    logic [Width-1:0] acc;
    acc = 1;
    if (a[Width-1] || a >= 2 * Width) return '0;
    for (int unsigned i = 2; i <= a; i++) acc = acc * Width'(i);
    return acc;
  endfunction

  function automatic logic [Width-1:0] calc_result(input logic [Width-1:0] a,
                                                   input logic [Width-1:0] b,
                                                   input logic [2:0] op);
    case (op)
      icalc_pkg::OpAdd:  return a + b;
      icalc_pkg::OpSub:  return a - b;
      icalc_pkg::OpMul:  return a * b;
      icalc_pkg::OpDiv:  return divide_result(a, b, 1'b0);
      icalc_pkg::OpPow:  return power_result(a, b);
      icalc_pkg::OpRem:  return divide_result(a, b, 1'b1);
      icalc_pkg::OpFact: return factorial_result(a);
      default:           return ($signed(a) < $signed(b)) ? b : a;
    endcase
  endfunction

  // Offer one beat, with optional idle cycles first, and wait for acceptance.
  task automatic send_op(input logic [Width-1:0] a, input logic [Width-1:0] b,
                         input logic [2:0] op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    mode_i      <= op;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(calc_result(a, b, op));
    sent_count++;
    op_count[op]++;
  endtask

  function automatic logic [Width-1:0] pick_operand();
    case ($urandom_range(3))
      0: return Width'($urandom);
      1: return Width'($signed($urandom_range(40)) - 20);
      2: begin
        case ($urandom_range(4))
          0: return '0;
          1: return 1;
          2: return '1;
          3: return {1'b1, {(Width-1){1'b0}}};
          default: return {1'b0, {(Width-1){1'b1}}};
        endcase
      end
      default: return Width'($urandom >> $urandom_range(Width - 1));
    endcase
  endfunction

  // Random beat; power and factorial mostly use small exponents and arguments.
  task automatic send_random_op();
    logic [Width-1:0] a, b;
    logic [2:0] op;
    op = 3'($urandom_range(7));
    a  = pick_operand();
    b  = pick_operand();
    if (op == icalc_pkg::OpPow && $urandom_range(19) != 0) b = Width'($urandom_range(20));
    if (op == icalc_pkg::OpFact && $urandom_range(9) != 0) a = Width'($urandom_range(70));
    send_op(a, b, op);
  endtask

  task automatic test_directed();
    logic [Width-1:0] min_val, max_val;
    min_val = {1'b1, {(Width-1){1'b0}}};
    max_val = {1'b0, {(Width-1){1'b1}}};
    send_op(max_val, 1, icalc_pkg::OpAdd);
    send_op(min_val, 1, icalc_pkg::OpSub);
    send_op(max_val, max_val, icalc_pkg::OpMul);
    send_op(min_val, '1, icalc_pkg::OpMul);
    send_op(7, '0, icalc_pkg::OpDiv);
    send_op(7, '0, icalc_pkg::OpRem);
    send_op(min_val, '1, icalc_pkg::OpDiv);
    send_op(min_val, '1, icalc_pkg::OpRem);
    send_op(-7, 2, icalc_pkg::OpDiv);
    send_op(-7, 2, icalc_pkg::OpRem);
    send_op(7, -2, icalc_pkg::OpDiv);
    send_op(7, -2, icalc_pkg::OpRem);
    send_op(3, '0, icalc_pkg::OpPow);
    send_op(3, -5, icalc_pkg::OpPow);
    send_op(-3, 19, icalc_pkg::OpPow);
    send_op(2, max_val, icalc_pkg::OpPow);
    send_op(-4, 0, icalc_pkg::OpFact);
    send_op('0, 0, icalc_pkg::OpFact);
    send_op(12, 0, icalc_pkg::OpFact);
    send_op(63, 0, icalc_pkg::OpFact);
    send_op(64, 0, icalc_pkg::OpFact);
    send_op(min_val, max_val, icalc_pkg::OpMax);
    send_op(-5, -5, icalc_pkg::OpMax);
    send_op('1, '0, icalc_pkg::OpMax);
  endtask

  task automatic test_random(input int unsigned count, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_op();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 400;
    repeat (12) send_random_op();
  endtask

  // Output side: stall control and in-order result checking.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (mismatch_count++ < MaxReports)
            $display("Unexpected result beat %h at cycle %0d", result_o, cycle_count);
        end else begin
          logic [Width-1:0] want;
          want = pending_results.pop_front();
          checked_count++;
          if (result_o !== want) begin
            error_count++;
            if (mismatch_count++ < MaxReports)
              $display("Result mismatch: expected %h, got %h", want, result_o);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Run-length guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(150, 0, 0);
    test_random(150, 74, 0);
    test_random(150, 0, 74);
    test_random(150, 8, 8);
    test_backpressure();
    in_valid_i <= 1'b0;
    recv_stall_pct = 20;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    error_count += pending_results.size();
    $display("Sent %0d beats, checked %0d results over %0d cycles.",
             sent_count, checked_count, cycle_count);
    $display("Per operation add..max: %0d %0d %0d %0d %0d %0d %0d %0d",
             op_count[0], op_count[1], op_count[2], op_count[3],
             op_count[4], op_count[5], op_count[6], op_count[7]);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
